// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the serial wheel mouse packet decoder.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WIN_DEPTH = 3;
    localparam int unsigned SYNC_POS = 6;

    typedef logic [1:0] t_count;

    localparam t_count COUNT_EMPTY = 2'd0;
    localparam t_count COUNT_FULL  = 2'd3;

    typedef struct packed {
        logic              header_error;
        logic [2:0]        buttons;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [3:0] delta_wheel;
    } t_result;

    // Header bits 5:4 (left, right) mapped onto the result button layout.
    function automatic logic [2:0] button_map(input logic [1:0] idx);
        logic [2:0] btn;
        unique case (idx)
            2'd0:    btn = 3'd0;
            2'd1:    btn = 3'd1;
            2'd2:    btn = 3'd4;
            2'd3:    btn = 3'd5;
            default: btn = 3'd0;
        endcase
        return btn;
    endfunction

endpackage

// ----- rtl/core/swm_window.sv -----
// ----------------------------------------------------------------------------
// swm_window
// Byte window of the packet decoder with the sync check and packet decode.
// ----------------------------------------------------------------------------
module swm_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [swm_pkg::BYTE_W-1:0]     i_byte,
    output logic                           o_res_vld,
    output swm_pkg::t_result               o_res
);
    import swm_pkg::*;

    logic [BYTE_W-1:0] r_bytes [WIN_DEPTH];
    t_count            r_count;
    t_count            n_count;
    logic              full;
    logic              synced;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [2:0]        btn;

    assign hdr    = r_bytes[0];
    assign b1     = r_bytes[1];
    assign b2     = r_bytes[2];
    assign full   = (r_count == COUNT_FULL);
    assign synced = hdr[SYNC_POS];

    assign o_res_vld = full;

    always_comb begin
        btn = button_map(hdr[5:4]) | {1'b0, i_byte[4], 1'b0};
        o_res = '0;
        if (!synced) begin
            o_res.header_error = 1'b1;
        end else begin
            o_res.buttons     = btn;
            o_res.delta_x     = {hdr[1:0], b1[5:0]};
            o_res.delta_y     = {hdr[3:2], b2[5:0]};
            o_res.delta_wheel = i_byte[3:0];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_step) begin
            priority if (!full) begin
                n_count = r_count + 2'd1;
            end else if (!synced) begin
                n_count = COUNT_FULL;
            end else begin
                n_count = COUNT_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_EMPTY;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (!full) begin
                r_bytes[r_count] <= i_byte;
            end else if (!synced) begin
                r_bytes[0] <= b1;
                r_bytes[1] <= b2;
                r_bytes[2] <= i_byte;
            end
        end
    end

    a_short_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != COUNT_FULL) |-> !o_res_vld)
        else $error("Result flagged before the window was full.");

    a_error_keeps_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_vld && o_res.header_error) |=> (r_count == COUNT_FULL))
        else $error("Header error did not keep three bytes.");

    a_packet_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_vld && !o_res.header_error) |=> (r_count == COUNT_EMPTY))
        else $error("Packet did not empty the window.");

endmodule

// ----- rtl/core/serial_wheel_mouse_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// serial_wheel_mouse_packet_decoder
// Decodes four-byte serial wheel mouse packets into buttons and deltas.
// ----------------------------------------------------------------------------
// The block takes one received byte per request, at up to one byte every
// cycle, and gives one result for each byte that arrives while its window
// holds three bytes: a decoded packet when the window's first byte carries
// the sync bit, or a header error after which the window slides forward by
// one byte. A byte passes an input register, the window update and decode,
// and lands in the result register; a stalled result blocks new bytes only
// when another result is due.
module serial_wheel_mouse_packet_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_header_error,
    output logic [2:0]        o_buttons,
    output logic signed [7:0] o_delta_x,
    output logic signed [7:0] o_delta_y,
    output logic signed [3:0] o_delta_wheel
);
    import swm_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    logic              res_vld;
    t_result           res;
    logic              out_free;
    logic              step;

    assign out_free = !r_out_vld || i_ready;
    assign step     = r_in_vld && (!res_vld || out_free);
    assign o_ready  = !r_in_vld || step;

    swm_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (step && res_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && res_vld) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_header_error = r_out.header_error;
    assign o_buttons      = r_out.buttons;
    assign o_delta_x      = r_out.delta_x;
    assign o_delta_y      = r_out.delta_y;
    assign o_delta_wheel  = r_out.delta_wheel;

    a_stall_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_vld && r_out_vld && !i_ready))
        else $error("Input stalled without a pending result.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res_vld) |=> o_valid)
        else $error("Decoded result was not presented.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_header_error) |-> (o_buttons == 3'd0 && o_delta_x == 8'sd0
            && o_delta_y == 8'sd0 && o_delta_wheel == 4'sd0))
        else $error("Header error result carries packet fields.");

endmodule

// ----- dv/tb_serial_wheel_mouse_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_serial_wheel_mouse_packet_decoder
// Self-checking testbench for the serial wheel mouse packet decoder.
// ----------------------------------------------------------------------------
// A driver sends received mouse bytes from a queue. A monitor decodes every
// accepted byte with a behavioral window model and checks each result, in
// order, against the oldest decoded packet or header error. Directed packets
// cover the field extremes and resync after lost sync. Random traffic follows,
// mostly well-formed packets with noise and truncated packets mixed in. The
// phases run with no idling, an idle sender, a stalling receiver, light
// idling on both sides, and one long receiver hold-off that backs up the input.
module tb_serial_wheel_mouse_packet_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] SYNC_MASK = 8'h40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_rx_byte = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_header_error;
    logic [2:0] o_buttons;
    logic signed [7:0] o_delta_x;
    logic signed [7:0] o_delta_y;
    logic signed [3:0] o_delta_wheel;

    logic [7:0] pending_bytes[$];
    t_result expected_reports[$];

    logic [BYTE_W-1:0] win_bytes[WIN_DEPTH];
    t_count win_count = COUNT_EMPTY;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit hold_trigger = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int packets_seen = 0;
    int sync_errors_seen = 0;

    serial_wheel_mouse_packet_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_header_error (o_header_error),
        .o_buttons      (o_buttons),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_delta_wheel  (o_delta_wheel)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit decode_mouse_byte(input logic [7:0] rx, output t_result rpt);
        logic [7:0] hdr;
        rpt = '0;
        if (win_count != COUNT_FULL) begin
            win_bytes[win_count] = rx;
            win_count = win_count + 1'b1;
            return 1'b0;
        end
        hdr = win_bytes[0];
        if (!hdr[SYNC_POS]) begin
            rpt.header_error = 1'b1;
            win_bytes[0] = win_bytes[1];
            win_bytes[1] = win_bytes[2];
            win_bytes[2] = rx;
            return 1'b1;
        end
        rpt.buttons = {hdr[5], rx[4], hdr[4]};
        rpt.delta_x = {hdr[1:0], win_bytes[1][5:0]};
        rpt.delta_y = {hdr[3:2], win_bytes[2][5:0]};
        rpt.delta_wheel = rx[3:0];
        win_count = COUNT_EMPTY;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic push_packet(input int len);
        logic [7:0] hdr;
        hdr = 8'($urandom) | SYNC_MASK;
        pending_bytes.push_back(hdr);
        for (int k = 1; k < len; k++) begin
            pending_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic queue_traffic(input int n);
        int start;
        int pick;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                push_packet(4);
            end else if (pick < 90) begin
                pending_bytes.push_back(8'($urandom) & ~SYNC_MASK);
            end else begin
                push_packet($urandom_range(3, 1));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int n);
        @(negedge i_clk);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        queue_traffic(n);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_rx_byte <= '0;
        end else if (!i_valid || o_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_valid <= 1'b1;
                i_rx_byte <= pending_bytes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                bytes_sent++;
                if (decode_mouse_byte(i_rx_byte, want)) begin
                    expected_reports.push_back(want);
                end
            end
            if (o_valid && i_ready) begin
                got = {o_header_error, o_buttons, o_delta_x, o_delta_y, o_delta_wheel};
                if (expected_reports.size() == 0) begin
                    note_mismatch($sformatf("result with none expected: err=%0b btn=%0d",
                        got.header_error, got.buttons));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.header_error) begin
                        sync_errors_seen++;
                    end else begin
                        packets_seen++;
                    end
                    if (got !== want) begin
                        note_mismatch($sformatf(
                            "exp err=%0b btn=%0d dx=%0d dy=%0d wh=%0d, got err=%0b btn=%0d dx=%0d dy=%0d wh=%0d",
                            want.header_error, want.buttons, want.delta_x, want.delta_y,
                            want.delta_wheel, got.header_error, got.buttons, got.delta_x,
                            got.delta_y, got.delta_wheel));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_serial_wheel_mouse_packet_decoder: errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        // Field extremes, ignored high bits, then loss of sync and recovery.
        pending_bytes = '{8'h40, 8'h00, 8'h00, 8'h00,
                          8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          8'h62, 8'hC0, 8'h3F, 8'hE8,
                          8'h58, 8'h3F, 8'h80, 8'h17,
                          8'h00, 8'h40, 8'h01, 8'h02, 8'h03,
                          8'hBF, 8'h80, 8'h80, 8'h80};
        wait_drained();

        run_phase(0, 0, 340);
        run_phase(81, 0, 340);
        run_phase(0, 81, 340);
        run_phase(16, 16, 340);

        @(negedge i_clk);
        hold_trigger = 1'b1;
        run_phase(0, 0, 160);

        while (expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d bytes; checked %0d packets and %0d header errors.",
            bytes_sent, packets_seen, sync_errors_seen);
        $display("Idling phases plus a %0d-cycle receiver hold-off; %0d mismatches.",
            HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb_serial_wheel_mouse_packet_decoder: clean");
        end else begin
            $display("tb_serial_wheel_mouse_packet_decoder: errors");
        end
        $finish;
    end

endmodule
